[sv/ipv4dp_pkg.sv]
// ============================================================================
// ipv4dp_pkg - shared types for the dotted IPv4 address parser
// Character classes, status codes and the word formats passed between the
// front end, the middle queue and the parse engine.
// ============================================================================
package ipv4dp_pkg;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_DEC,
    CLS_HEXL,
    CLS_DOT,
    CLS_X,
    CLS_SPACE,
    CLS_OTHER
  } char_cls_t;

  // classified input byte: class plus digit value (0-9 or 10-15)
  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
  } char_word_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_OCTAL      = 3'd2,
    ST_DOTTED     = 3'd3,
    ST_JUNK       = 3'd4,
    ST_EMPTY_LAST = 3'd5,
    ST_LAST_BIG   = 3'd6,
    ST_OVERFLOW   = 3'd7
  } status_t;

  typedef struct packed {
    logic [31:0] address;
    logic        address_ok;
    status_t     status;
  } result_t;

  // largest value the last part may take, by number of dotted parts before it
  function automatic logic [31:0] last_limit(input logic [1:0] parts);
    logic [31:0] lim;
    case (parts)
      2'd0:    lim = 32'hFFFF_FFFF;
      2'd1:    lim = 32'h00FF_FFFF;
      2'd2:    lim = 32'h0000_FFFF;
      default: lim = 32'h0000_00FF;
    endcase
    return lim;
  endfunction

endpackage

[sv/ipv4dp_front.sv]
// ============================================================================
// ipv4dp_front - input stage
// Accepts one byte per cycle while in_full is low, classifies it and holds
// the classified word until the middle queue takes it.
// ============================================================================
module ipv4dp_front
  import ipv4dp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char_code,
  output logic       in_full,
  output char_word_t word,
  output logic       word_valid,
  input  logic       word_full
);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CASE_BIT = 8'h20;

  logic       valid_r, valid_nxt;
  char_word_t word_r;
  char_word_t cls_word;
  logic       accept;
  logic       sent;
  logic [7:0] lc;

  assign in_full = valid_r && word_full;
  assign accept  = in_push && !in_full;
  assign sent    = valid_r && !word_full;

  // classify the byte
  always_comb begin
    lc = in_char_code | CASE_BIT;
    cls_word.digit = in_char_code[3:0];
    if (in_char_code == CH_NUL) begin
      cls_word.cls = CLS_NUL;
    end else if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) begin
      cls_word.cls = CLS_DEC;
    end else if (lc >= CH_LA && lc <= CH_LF) begin
      cls_word.cls   = CLS_HEXL;
      cls_word.digit = lc[3:0] + 4'd9;
    end else if (in_char_code == CH_DOT) begin
      cls_word.cls = CLS_DOT;
    end else if (in_char_code == CH_LX || in_char_code == CH_UX) begin
      cls_word.cls = CLS_X;
    end else if (in_char_code == CH_SP ||
                 (in_char_code >= CH_TAB && in_char_code <= CH_CR)) begin
      cls_word.cls = CLS_SPACE;
    end else begin
      cls_word.cls = CLS_OTHER;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (sent) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= cls_word;
    end
  end

  assign word       = word_r;
  assign word_valid = valid_r;

endmodule

[sv/ipv4dp_queue.sv]
// ============================================================================
// ipv4dp_queue - small first-in first-out queue
// Show-ahead register queue; full and empty come straight from the count.
// ============================================================================
module ipv4dp_queue #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count_r == CNT_MAX);
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("queue count beyond depth");
`endif

endmodule

[sv/ipv4dp_back.sv]
// ============================================================================
// ipv4dp_back - parse engine
// Runs the part/base/digit state machine on classified words and writes one
// result word per terminating NUL into the result queue.
// ============================================================================
module ipv4dp_back
  import ipv4dp_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  char_word_t  word,
  input  logic        word_empty,
  output logic        word_pop,
  output logic [31:0] out_address,
  output logic        out_address_ok,
  output logic [2:0]  out_status,
  output logic        out_empty,
  input  logic        out_pop
);

  localparam int unsigned RES_W = $bits(result_t);

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGIT,
    PH_HOLD
  } phase_t;

  typedef enum logic [1:0] {
    B_DEC,
    B_OCT,
    B_HEX
  } base_t;

  phase_t      phase_r, phase_nxt;
  base_t       base_r, base_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic        dseen_r, dseen_nxt;
  status_t     held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  pb_r [3];
  logic [7:0]  pb_nxt [3];

  logic             take;
  logic             do_digit;
  logic [36:0]      prod;
  logic             res_wr;
  result_t          res_word;
  logic             res_full;
  logic [RES_W-1:0] res_data;
  result_t          res_out;

  assign take     = !word_empty && !res_full;
  assign word_pop = take;

  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    dseen_nxt = dseen_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    pb_nxt    = pb_r;
    do_digit  = 1'b0;
    prod      = '0;
    res_wr    = 1'b0;
    res_word  = '0;

    if (take) begin
      case (phase_r)
        PH_START: begin
          if (word.cls == CLS_DEC) begin
            acc_nxt   = {28'd0, word.digit};
            base_nxt  = B_DEC;
            dseen_nxt = (word.digit != 4'd0);
            ovf_nxt   = 1'b0;
            phase_nxt = (word.digit == 4'd0) ? PH_ZERO : PH_DIGIT;
          end else begin
            held_nxt  = ST_BAD_START;
            phase_nxt = PH_HOLD;
          end
        end
        PH_ZERO: begin
          if (word.cls == CLS_X) begin
            base_nxt  = B_HEX;
            dseen_nxt = 1'b0;
            phase_nxt = PH_DIGIT;
          end else begin
            // leading zero: octal, and this byte is a digit-phase byte
            base_nxt  = B_OCT;
            dseen_nxt = 1'b1;
            phase_nxt = PH_DIGIT;
            do_digit  = 1'b1;
          end
        end
        PH_DIGIT: begin
          do_digit = 1'b1;
        end
        default: ;
      endcase

      if (do_digit) begin
        if (word.cls == CLS_DEC && base_nxt == B_OCT && word.digit >= 4'd8) begin
          held_nxt  = ST_OCTAL;
          phase_nxt = PH_HOLD;
        end else if (word.cls == CLS_DEC ||
                     (word.cls == CLS_HEXL && base_nxt == B_HEX)) begin
          // shift-add accumulate, keeping the carry out for overflow
          case (base_nxt)
            B_OCT:   prod = {2'b00, acc_r, 3'b000};
            B_HEX:   prod = {1'b0, acc_r, 4'b0000};
            default: prod = {2'b00, acc_r, 3'b000} + {4'b0000, acc_r, 1'b0};
          endcase
          prod      = prod + {33'd0, word.digit};
          ovf_nxt   = ovf_r | (|prod[36:32]);
          acc_nxt   = prod[31:0];
          dseen_nxt = 1'b1;
        end else if (word.cls == CLS_DOT) begin
          if (ovf_r) begin
            held_nxt  = ST_OVERFLOW;
            phase_nxt = PH_HOLD;
          end else if (cnt_r == 2'd3 || acc_r > 32'h0000_00FF) begin
            held_nxt  = ST_DOTTED;
            phase_nxt = PH_HOLD;
          end else begin
            pb_nxt[cnt_r] = acc_r[7:0];
            cnt_nxt       = cnt_r + 2'd1;
            phase_nxt     = PH_START;
          end
        end else begin
          // parsing ends here: settle the verdict
          if (ovf_r) begin
            held_nxt = ST_OVERFLOW;
          end else if (word.cls != CLS_NUL && word.cls != CLS_SPACE) begin
            held_nxt = ST_JUNK;
          end else if (!dseen_nxt) begin
            held_nxt = ST_EMPTY_LAST;
          end else if (acc_r > last_limit(cnt_r)) begin
            held_nxt = ST_LAST_BIG;
          end else begin
            held_nxt = ST_OK;
          end
          phase_nxt = PH_HOLD;
        end
      end

      if (word.cls == CLS_NUL) begin
        res_wr              = 1'b1;
        res_word.status     = held_nxt;
        res_word.address_ok = (held_nxt == ST_OK);
        res_word.address    = (held_nxt == ST_OK) ?
                              ({pb_r[0], pb_r[1], pb_r[2], 8'h00} | acc_nxt) : 32'd0;
        // start afresh for the next string
        phase_nxt = PH_START;
        base_nxt  = B_DEC;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        dseen_nxt = 1'b0;
        held_nxt  = ST_OK;
        cnt_nxt   = '0;
        pb_nxt[0] = '0;
        pb_nxt[1] = '0;
        pb_nxt[2] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      base_r  <= B_DEC;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      dseen_r <= 1'b0;
      held_r  <= ST_OK;
      cnt_r   <= '0;
      pb_r[0] <= '0;
      pb_r[1] <= '0;
      pb_r[2] <= '0;
    end else begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      dseen_r <= dseen_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
      pb_r    <= pb_nxt;
    end
  end

  ipv4dp_queue #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (RES_W)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_data),
    .empty   (out_empty)
  );

  assign res_out        = result_t'(res_data);
  assign out_address    = res_out.address;
  assign out_address_ok = res_out.address_ok;
  assign out_status     = res_out.status;

`ifndef NO_ASSERTIONS
  a_res_on_nul: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> (take && word.cls == CLS_NUL))
    else $error("result written without a terminating NUL");

  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> (res_word.address_ok == (res_word.status == ST_OK)))
    else $error("ok flag disagrees with status");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_wr && !res_word.address_ok) |-> (res_word.address == 32'd0))
    else $error("invalid result carries an address");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && word.cls == CLS_NUL) |=> (phase_r == PH_START && cnt_r == 2'd0))
    else $error("parser not restarted after NUL");
`endif

endmodule

[sv/ipv4dp_core.sv]
// ============================================================================
// ipv4_dotted_address_parser_core - streaming dotted IPv4 address parser
// Front end classifies bytes, a short queue decouples it from the parse
// engine, and a result queue holds finished addresses.
// ============================================================================
// Usage
//   Input: write one text byte per word with in_push while in_full is low.
//   The text is inet_aton style: one to four parts split by '.', each part
//   decimal, octal (leading 0) or hex (0x / 0X); a NUL byte ends the string.
//   Output: for every NUL one result word appears with out_empty low, carrying
//   out_address (first part most significant), out_address_ok and
//   out_status; take it with out_pop. Other bytes give no result.
// Timing
//   One byte per cycle, sustained while out_pop drains results. A NUL's
//   result passes through the front register and then the middle queue;
//   the parse engine pops it and writes the result queue on the same edge.
//   The parse engine handles one word per cycle while the result queue has
//   room; its shift-add accumulate is the longest path.
// Reset and stalls
//   rst_n (synchronous, active low) empties both queues and returns the
//   parser to the start of a string. While out_pop stays low the result
//   queue fills, the parse engine holds, the middle queue fills and in_full
//   rises; nothing is lost and bytes resume as soon as results drain.
// ============================================================================
module ipv4_dotted_address_parser_core
  import ipv4dp_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_address,
  output logic        out_address_ok,
  output logic [2:0]  out_status
);

  localparam int unsigned WORD_W = $bits(char_word_t);

  char_word_t          front_word;
  logic                front_valid;
  logic                mid_full;
  logic [WORD_W-1:0]   mid_data;
  char_word_t          mid_word;
  logic                mid_empty;
  logic                mid_pop;

  // classify and register each accepted byte
  ipv4dp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .word         (front_word),
    .word_valid   (front_valid),
    .word_full    (mid_full)
  );

  // decouple the front end from the parse engine
  ipv4dp_queue #(
    .DEPTH (MID_DEPTH),
    .WIDTH (WORD_W)
  ) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_data (front_word),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_data),
    .empty   (mid_empty)
  );

  assign mid_word = char_word_t'(mid_data);

  // advance the parse state and queue the results
  ipv4dp_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .word           (mid_word),
    .word_empty     (mid_empty),
    .word_pop       (mid_pop),
    .out_address    (out_address),
    .out_address_ok (out_address_ok),
    .out_status     (out_status),
    .out_empty      (out_empty),
    .out_pop        (out_pop)
  );

endmodule
